>>> src/fatm_pkg.sv
package fatm_pkg;

  // Item opcodes on the request channel
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_FAIL  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_READ_REQ  = 3'd0;
  localparam logic [2:0] ST_MOUNTED   = 3'd1;
  localparam logic [2:0] ST_READ_ERR  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_NOT_MOUNT = 3'd4;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // Classified command between front and back
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } fatm_item_t;

  // Nonzero when the byte at this offset breaks a signature check
  function automatic logic byte_mismatch(input logic info, input logic [8:0] idx,
                                         input logic [7:0] b);
    logic       chk;
    logic [7:0] want;
    chk  = 1'b0;
    want = 8'h00;
    case (idx)
      9'd510: begin chk = 1'b1; want = 8'h55; end
      9'd511: begin chk = 1'b1; want = 8'hAA; end
      9'd0, 9'd1: begin chk = info; want = 8'h52; end
      9'd2: begin chk = info; want = 8'h61; end
      9'd3: begin chk = info; want = 8'h41; end
      9'h1E4, 9'h1E5: begin chk = info; want = 8'h72; end
      9'h1E6: begin chk = info; want = 8'h41; end
      9'h1E7: begin chk = info; want = 8'h61; end
      default: begin chk = 1'b0; want = 8'h00; end
    endcase
    return chk && (want != b);
  endfunction

endpackage

>>> src/fatm_in_if.sv
interface fatm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] sector_byte;

  modport source (output valid, output op, output sector_byte, input ready);
  modport sink (input valid, input op, input sector_byte, output ready);
endinterface

>>> src/fatm_out_if.sv
interface fatm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] read_lba;
  logic [31:0] partition_lba;
  logic [31:0] fat_lba;
  logic [31:0] cluster_lba;
  logic [31:0] info_lba;
  logic [31:0] root_cluster;
  logic [7:0]  cluster_sectors;
  logic [31:0] free_clusters;
  logic [31:0] recent_cluster;

  modport source (output valid, output status, output read_lba, output partition_lba,
                  output fat_lba, output cluster_lba, output info_lba,
                  output root_cluster, output cluster_sectors, output free_clusters,
                  output recent_cluster, input ready);
  modport sink (input valid, input status, input read_lba, input partition_lba,
                input fat_lba, input cluster_lba, input info_lba,
                input root_cluster, input cluster_sectors, input free_clusters,
                input recent_cluster, output ready);
endinterface

>>> src/fatm_front.sv
module fatm_front (
  input  logic               clk,
  input  logic               rst,
  fatm_in_if.sink            req,
  output logic               item_valid,
  output fatm_pkg::fatm_item_t item,
  input  logic               item_ready
);

  logic valid;
  logic keep;

  assign req.ready  = !valid || item_ready;
  // drop the unused opcode: no result, no state change
  assign keep       = (req.op == fatm_pkg::OP_START) || (req.op == fatm_pkg::OP_BYTE) ||
                      (req.op == fatm_pkg::OP_FAIL);
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item.cmd  <= req.op;
      item.data <= req.sector_byte;
    end
  end

endmodule

>>> src/fatm_queue.sv
module fatm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  fatm_pkg::fatm_item_t push_item,
  output logic                 push_ready,
  output logic                 pop_valid,
  output fatm_pkg::fatm_item_t pop_item,
  input  logic                 pop_ready
);

  fatm_pkg::fatm_item_t slots [fatm_pkg::QueueDepth];
  logic [fatm_pkg::QueueAw-1:0] wr_ptr;
  logic [fatm_pkg::QueueAw-1:0] rd_ptr;
  logic [fatm_pkg::QueueAw:0]   count;
  logic push;
  logic pop;

  assign push_ready = (count != (fatm_pkg::QueueAw+1)'(fatm_pkg::QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

>>> src/fatm_back.sv
module fatm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  fatm_pkg::fatm_item_t item,
  output logic                 item_ready,
  fatm_out_if.source           rsp
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEC0 = 2'd1;
  localparam logic [1:0] PH_BOOT = 2'd2;
  localparam logic [1:0] PH_INFO = 2'd3;

  logic [1:0]  phase;
  logic [8:0]  byte_index;
  logic        signature_good;
  logic [7:0]  jmp0, jmp2, spc, nfat, drv, ext;
  logic [31:0] partition_base, mbr_entry_lba, fat_sectors, root_start;
  logic [31:0] free_count, recent_alloc;
  logic [15:0] sector_size, reserved_count, info_offset;

  logic        out_valid;
  logic        pop;
  logic        is_byte;
  logic        sig_new;
  logic        boot_like;
  logic        boot_ok;
  logic        emit;
  logic [1:0]  phase_next;
  logic [2:0]  status;
  logic [31:0] rlba;
  logic [31:0] pb_next;
  logic [31:0] fat_now;
  logic [31:0] prod;
  logic [1:0]  mbr_lane;

  assign rsp.valid  = out_valid;
  assign item_ready = !out_valid || rsp.ready;
  assign pop        = item_valid && item_ready;
  assign is_byte    = (item.cmd == fatm_pkg::OP_BYTE) && (phase != PH_IDLE);
  // partition entry LBA starts at offset 454, which sits at lane 2 of its word
  assign mbr_lane   = byte_index[1:0] - 2'd2;

  assign sig_new = ((byte_index == 9'd0) ? 1'b1 : signature_good) &&
                   !fatm_pkg::byte_mismatch(phase == PH_INFO, byte_index, item.data);
  assign boot_like = ((jmp0 == 8'hEB && jmp2 == 8'h90) || jmp0 == 8'hE9) &&
                     (spc != 8'd0) && ((spc & (spc - 8'd1)) == 8'd0) && (nfat != 8'd0);
  assign boot_ok = sig_new && ext == 8'h29 && (drv == 8'h00 || drv == 8'h80) &&
                   sector_size == 16'd512;

  always_comb begin
    phase_next = phase;
    pb_next    = partition_base;
    emit       = 1'b0;
    status     = fatm_pkg::ST_READ_REQ;
    rlba       = 32'd0;
    case (item.cmd)
      fatm_pkg::OP_START: begin
        phase_next = PH_SEC0;
        emit       = 1'b1;
      end
      default: begin
        if (phase == PH_IDLE) begin
          emit   = 1'b1;
          status = fatm_pkg::ST_NOT_MOUNT;
        end else if (item.cmd == fatm_pkg::OP_FAIL) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          status     = fatm_pkg::ST_READ_ERR;
        end else if (byte_index == 9'd511) begin
          emit = 1'b1;
          if (phase == PH_SEC0 && !boot_like) begin
            if (!sig_new) begin
              phase_next = PH_IDLE;
              status     = fatm_pkg::ST_UNKNOWN;
            end else begin
              pb_next    = mbr_entry_lba;
              phase_next = PH_BOOT;
              rlba       = mbr_entry_lba;
            end
          end else if (phase == PH_SEC0 || phase == PH_BOOT) begin
            if (phase == PH_SEC0) pb_next = 32'd0;
            if (!boot_ok) begin
              phase_next = PH_IDLE;
              status     = fatm_pkg::ST_UNKNOWN;
            end else begin
              phase_next = PH_INFO;
              rlba       = {16'd0, info_offset} + pb_next;
            end
          end else begin
            phase_next = PH_IDLE;
            status     = sig_new ? fatm_pkg::ST_MOUNTED : fatm_pkg::ST_UNKNOWN;
          end
        end
      end
    endcase
  end

  assign fat_now = pb_next + {16'd0, reserved_count};
  assign prod    = {24'd0, nfat} * fat_sectors;

  // mount state and field capture
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_index     <= 9'd0;
      signature_good <= 1'b1;
      jmp0 <= 8'd0; jmp2 <= 8'd0; spc <= 8'd0; nfat <= 8'd0; drv <= 8'd0; ext <= 8'd0;
      partition_base <= 32'd0;
      mbr_entry_lba  <= 32'd0;
      sector_size    <= 16'd0;
      reserved_count <= 16'd0;
      fat_sectors    <= 32'd0;
      root_start     <= 32'd0;
      info_offset    <= 16'd0;
      free_count     <= 32'd0;
      recent_alloc   <= 32'd0;
    end else if (pop) begin
      phase          <= phase_next;
      partition_base <= pb_next;
      if (item.cmd == fatm_pkg::OP_START) begin
        byte_index     <= 9'd0;
        signature_good <= 1'b1;
      end else if (phase != PH_IDLE && item.cmd == fatm_pkg::OP_FAIL) begin
        byte_index <= 9'd0;
      end else if (is_byte) begin
        byte_index     <= byte_index + 9'd1;
        signature_good <= sig_new;
        if (phase == PH_INFO) begin
          if (byte_index[8:2] == 7'h7A) free_count[byte_index[1:0]*8 +: 8] <= item.data;
          if (byte_index[8:2] == 7'h7B) recent_alloc[byte_index[1:0]*8 +: 8] <= item.data;
        end else begin
          case (byte_index)
            9'd0:    jmp0 <= item.data;
            9'd2:    jmp2 <= item.data;
            9'd11:   sector_size[7:0] <= item.data;
            9'd12:   sector_size[15:8] <= item.data;
            9'd13:   spc <= item.data;
            9'd14:   reserved_count[7:0] <= item.data;
            9'd15:   reserved_count[15:8] <= item.data;
            9'd16:   nfat <= item.data;
            9'h30:   info_offset[7:0] <= item.data;
            9'h31:   info_offset[15:8] <= item.data;
            9'h40:   drv <= item.data;
            9'h42:   ext <= item.data;
            default: ;
          endcase
          if (byte_index[8:2] == 7'd9) fat_sectors[byte_index[1:0]*8 +: 8] <= item.data;
          if (byte_index[8:2] == 7'd11) root_start[byte_index[1:0]*8 +: 8] <= item.data;
          if (phase == PH_SEC0 && byte_index >= 9'd454 && byte_index < 9'd458) begin
            mbr_entry_lba[{mbr_lane, 3'b000} +: 8] <= item.data;
          end
        end
      end
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      rsp.status          <= status;
      rsp.read_lba        <= rlba;
      rsp.partition_lba   <= pb_next;
      rsp.fat_lba         <= fat_now;
      rsp.cluster_lba     <= fat_now + prod;
      rsp.info_lba        <= {16'd0, info_offset} + pb_next;
      rsp.root_cluster    <= root_start;
      rsp.cluster_sectors <= spc;
      rsp.free_clusters   <= free_count;
      rsp.recent_cluster  <= recent_alloc;
    end
  end

endmodule

>>> src/fat32_volume_mount_parser.sv
// Channel | Dir | Payload                                     | Meaning
// req     | in  | op[1:0], sector_byte[7:0]                   | start, sector byte, read fail
// rsp     | out | status, read_lba, partition/fat/cluster/    | read request or mount outcome
//         |     | info_lba, root_cluster, cluster_sectors,    |
//         |     | free_clusters, recent_cluster               |
//
// One beat per cycle on req while req.ready is high; a result passes the front register,
// the queue and the result register on its way out.
// The back end retires one queued beat per cycle while the result register is free or
// being drained; a stalled rsp fills the four-entry queue and the front register, then
// drops req.ready.
// Synchronous active-high reset clears all mount state to idle; no clearing pass.
module fat32_volume_mount_parser (
  input logic        clk,
  input logic        rst,
  fatm_in_if.sink    req,
  fatm_out_if.source rsp
);

  logic                 f_valid;
  fatm_pkg::fatm_item_t f_item;
  logic                 f_ready;
  logic                 q_valid;
  fatm_pkg::fatm_item_t q_item;
  logic                 q_ready;

  // decode the beat and drop unused opcodes
  fatm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  // decouple decode from sector parsing
  fatm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  // track the mount phase, capture fields, build results
  fatm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .item_ready (q_ready),
    .rsp        (rsp)
  );

endmodule

>>> src/fatm_checker.sv
module fatm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] read_lba
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("rsp valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(read_lba))
    else $error("rsp payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("rsp valid right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 3'd4)
    else $error("status code out of range");

  a_lba_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != fatm_pkg::ST_READ_REQ |-> read_lba == 32'd0)
    else $error("read_lba set without a read request");

endmodule

bind fat32_volume_mount_parser fatm_checker u_fatm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .status    (rsp.status),
  .read_lba  (rsp.read_lba)
);
